// File: hdl/tte_pkg.sv
`default_nettype none
package tte_pkg;

	localparam int unsigned CMD_MAX = 6;
	localparam int unsigned CMD_CNT_W = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 24;

	typedef enum logic [1:0] {
		OP_BAR    = 2'd0,
		OP_SCROLL = 2'd1,
		OP_ERASE  = 2'd2,
		OP_GLYPH  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_GLYPH_WIDTH   = 3'd2,
		REG_GLYPH_HEIGHT  = 3'd3,
		REG_DEFAULT_COLOR = 3'd4
	} reg_idx_t;

	localparam logic [7:0] CH_ESC = 8'd27;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_END = 8'h6D;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_1   = 8'h31;
	localparam logic [7:0] CH_2   = 8'h32;
	localparam logic [7:0] CH_3   = 8'h33;
	localparam logic [7:0] CH_4   = 8'h34;
	localparam logic [7:0] CH_6   = 8'h36;
	localparam logic [7:0] CH_7   = 8'h37;

	localparam logic [23:0] COL_RED    = 24'hFF5555;
	localparam logic [23:0] COL_GREEN  = 24'h55FF55;
	localparam logic [23:0] COL_YELLOW = 24'hFFFF55;
	localparam logic [23:0] COL_BLUE   = 24'h5555FF;
	localparam logic [23:0] COL_CYAN   = 24'h55FFFF;
	localparam logic [23:0] COL_WHITE  = 24'hFFFFFF;

	typedef struct packed {
		op_t         op;
		logic [11:0] x;
		logic [11:0] y;
		logic [6:0]  glyph;
		logic [23:0] color;
	} cmd_t;

	typedef struct packed {
		logic [11:0] screen_width;
		logic [11:0] screen_height;
		logic [5:0]  glyph_width;
		logic [5:0]  glyph_height;
		logic [23:0] default_color;
	} cfg_t;

	typedef struct packed {
		logic [11:0] col;
		logic [11:0] row;
		logic [23:0] fg;
	} curs_t;

	function automatic cmd_t mk_cmd(op_t op, logic [12:0] x, logic [11:0] y,
		logic [6:0] glyph, logic [23:0] color);
		cmd_t c;
		c.op = op;
		c.x = x[12] ? 12'hFFF : x[11:0];
		c.y = y;
		c.glyph = glyph;
		c.color = color;
		return c;
	endfunction

endpackage
`default_nettype wire

// File: hdl/tte_step.sv
`default_nettype none
module tte_step #(
	parameter int unsigned EscW = 4,
	parameter int unsigned EscCap = 16
) (
	input  wire logic [7:0]           ch,
	input  wire tte_pkg::cfg_t        cfg,
	input  wire tte_pkg::curs_t       cur,
	input  wire logic                 esc,
	input  wire logic [EscW-1:0]      esc_cnt,
	input  wire logic [7:0]           esc_first,
	input  wire logic [7:0]           esc_second,
	output tte_pkg::curs_t            nxt,
	output logic                      esc_nxt,
	output logic [EscW-1:0]           esc_cnt_nxt,
	output logic [7:0]                esc_first_nxt,
	output logic [7:0]                esc_second_nxt,
	output tte_pkg::cmd_t             cmds [tte_pkg::CMD_MAX],
	output logic [tte_pkg::CMD_CNT_W-1:0] n_cmds
);
	import tte_pkg::*;

	logic [6:0]  line_h;
	logic [13:0] nl_sum;
	logic        nl_scroll;
	logic [11:0] nl_row;
	logic [12:0] tab_col;
	logic [12:0] adv_col;
	logic        wrap;

	// Line arithmetic shared by newline, tab overflow and wrap before print.
	always_comb begin
		line_h = {1'b0, cfg.glyph_height} + 7'd4;
		nl_sum = {2'b00, cur.row} + {7'd0, line_h} + {8'd0, cfg.glyph_height};
		nl_scroll = nl_sum >= {2'b00, cfg.screen_height};
		if (!nl_scroll) begin
			nl_row = cur.row + {5'd0, line_h};
		end else if (cfg.screen_height > {5'd0, line_h}) begin
			nl_row = cfg.screen_height - {5'd0, line_h};
		end else begin
			nl_row = '0;
		end
		tab_col = {1'b0, cur.col} + {5'd0, cfg.glyph_width, 2'b00};
		adv_col = {1'b0, cur.col} + {7'd0, cfg.glyph_width};
		wrap = adv_col >= {1'b0, cfg.screen_width};
	end

	always_comb begin
		logic [CMD_CNT_W-1:0] k;
		logic [11:0] col;
		logic [11:0] row;
		k = '0;
		col = cur.col;
		row = cur.row;
		nxt = cur;
		esc_nxt = esc;
		esc_cnt_nxt = esc_cnt;
		esc_first_nxt = esc_first;
		esc_second_nxt = esc_second;
		for (int i = 0; i < CMD_MAX; i++) begin
			cmds[i] = '0;
		end
		if (esc) begin
			if (ch == CH_END) begin
				esc_nxt = 1'b0;
				esc_cnt_nxt = '0;
				if (esc_cnt == EscW'(1) && esc_first == CH_0) begin
					nxt.fg = cfg.default_color;
				end else if (esc_cnt == EscW'(2) && esc_first == CH_3) begin
					unique case (esc_second)
						CH_7: nxt.fg = cfg.default_color;
						CH_1: nxt.fg = COL_RED;
						CH_2: nxt.fg = COL_GREEN;
						CH_3: nxt.fg = COL_YELLOW;
						CH_4: nxt.fg = COL_BLUE;
						CH_6: nxt.fg = COL_CYAN;
						default: nxt.fg = cur.fg;
					endcase
				end
			end else if (esc_cnt < EscW'(EscCap - 1)) begin
				if (esc_cnt == '0) begin
					esc_first_nxt = ch;
				end else if (esc_cnt == EscW'(1)) begin
					esc_second_nxt = ch;
				end
				esc_cnt_nxt = esc_cnt + EscW'(1);
			end
		end else if (ch == CH_ESC) begin
			esc_nxt = 1'b1;
			esc_cnt_nxt = '0;
		end else if (ch == CH_CR) begin
			nxt.col = '0;
		end else if (ch == CH_LF) begin
			cmds[k] = mk_cmd(OP_BAR, {1'b0, cur.col}, cur.row, 7'd0, 24'd0);
			k = k + 1'b1;
			if (nl_scroll) begin
				cmds[k] = mk_cmd(OP_SCROLL, 13'd0, 12'd0, 7'd0, 24'd0);
				k = k + 1'b1;
			end
			cmds[k] = mk_cmd(OP_BAR, 13'd0, nl_row, 7'd0, cur.fg);
			k = k + 1'b1;
			nxt.col = '0;
			nxt.row = nl_row;
		end else if (ch == CH_TAB) begin
			if (tab_col >= {1'b0, cfg.screen_width}) begin
				cmds[k] = mk_cmd(OP_BAR, tab_col, cur.row, 7'd0, 24'd0);
				k = k + 1'b1;
				if (nl_scroll) begin
					cmds[k] = mk_cmd(OP_SCROLL, 13'd0, 12'd0, 7'd0, 24'd0);
					k = k + 1'b1;
				end
				cmds[k] = mk_cmd(OP_BAR, 13'd0, nl_row, 7'd0, cur.fg);
				k = k + 1'b1;
				nxt.col = '0;
				nxt.row = nl_row;
			end else begin
				nxt.col = tab_col[11:0];
			end
		end else if (ch == CH_BS) begin
			cmds[k] = mk_cmd(OP_BAR, {1'b0, cur.col}, cur.row, 7'd0, 24'd0);
			k = k + 1'b1;
			if (cur.col >= {6'd0, cfg.glyph_width}) begin
				col = cur.col - {6'd0, cfg.glyph_width};
				cmds[k] = mk_cmd(OP_ERASE, {1'b0, col}, cur.row, 7'd0, 24'd0);
				k = k + 1'b1;
			end
			cmds[k] = mk_cmd(OP_BAR, {1'b0, col}, cur.row, 7'd0, cur.fg);
			k = k + 1'b1;
			nxt.col = col;
		end else begin
			cmds[k] = mk_cmd(OP_BAR, {1'b0, cur.col}, cur.row, 7'd0, 24'd0);
			k = k + 1'b1;
			if (wrap) begin
				// The wrap repeats the hide at the old column before moving down.
				cmds[k] = mk_cmd(OP_BAR, {1'b0, cur.col}, cur.row, 7'd0, 24'd0);
				k = k + 1'b1;
				if (nl_scroll) begin
					cmds[k] = mk_cmd(OP_SCROLL, 13'd0, 12'd0, 7'd0, 24'd0);
					k = k + 1'b1;
				end
				cmds[k] = mk_cmd(OP_BAR, 13'd0, nl_row, 7'd0, cur.fg);
				k = k + 1'b1;
				col = '0;
				row = nl_row;
			end
			if (!ch[7]) begin
				cmds[k] = mk_cmd(OP_GLYPH, {1'b0, col}, row, ch[6:0], cur.fg);
				k = k + 1'b1;
			end
			col = col + {6'd0, cfg.glyph_width};
			cmds[k] = mk_cmd(OP_BAR, {1'b0, col}, row, 7'd0, cur.fg);
			k = k + 1'b1;
			nxt.col = col;
			nxt.row = row;
		end
		n_cmds = k;
	end

endmodule
`default_nettype wire

// File: hdl/tte_cmd_queue.sv
`default_nettype none
module tte_cmd_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire tte_pkg::cmd_t                 cmds [tte_pkg::CMD_MAX],
	input  wire logic [tte_pkg::CMD_CNT_W-1:0] n_cmds,
	output logic                               room,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output tte_pkg::cmd_t                      head,
	output logic                               head_last
);
	import tte_pkg::*;

	cmd_t                 ent_q [CMD_MAX];
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign out_valid = cnt_q != '0;
	assign pop = out_valid && out_ready;
	// A new character's words may load once the last word of the previous one leaves.
	assign room = (cnt_q == '0) || (cnt_q == CMD_CNT_W'(1) && out_ready);
	assign head = ent_q[0];
	assign head_last = cnt_q == CMD_CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= n_cmds;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < CMD_MAX; i++) begin
				ent_q[i] <= cmds[i];
			end
		end else if (pop) begin
			for (int i = 0; i < CMD_MAX - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/text_terminal_cursor_engine.sv
`default_nettype none
// Character-stream terminal front end: each accepted byte updates the pixel cursor, the
// foreground colour and the escape collector, and produces zero to six draw words
// (cursor bar, scroll, erase cell, glyph). A byte is registered on input, its whole word
// list is formed combinationally and loaded into a six-entry command queue, which hands out
// one word per cycle while out_ready is high, and the next byte's list loads in the cycle
// the previous byte's final word is taken. Bytes that produce no words (escape text,
// return, a tab within the line) pass regardless of the queue. The user must write
// configuration through the cfg port only while idle; the block does not enforce this.
module text_terminal_cursor_engine #(
	parameter int unsigned ESCAPE_CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       op,
	output logic [11:0]      pos_x,
	output logic [11:0]      pos_y,
	output logic [6:0]       glyph_code,
	output logic [23:0]      paint_color,
	output logic             last
);
	import tte_pkg::*;

	localparam int unsigned EscW = $clog2(ESCAPE_CAPACITY);

	cfg_t            cfg_q;
	curs_t           cur_q;
	curs_t           cur_nxt;
	logic            esc_q, esc_nxt;
	logic [EscW-1:0] esc_cnt_q, esc_cnt_nxt;
	logic [7:0]      esc_first_q, esc_first_nxt;
	logic [7:0]      esc_second_q, esc_second_nxt;
	logic [7:0]      char_s1;
	logic            valid_s1;
	cmd_t            cmds [CMD_MAX];
	logic [CMD_CNT_W-1:0] n_cmds;
	logic            room;
	logic            adv;
	logic            load;
	cmd_t            head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width <= 12'd640;
			cfg_q.screen_height <= 12'd480;
			cfg_q.glyph_width <= 6'd8;
			cfg_q.glyph_height <= 6'd8;
			cfg_q.default_color <= COL_WHITE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data[11:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[11:0];
				REG_GLYPH_WIDTH: cfg_q.glyph_width <= cfg_data[5:0];
				REG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data[5:0];
				REG_DEFAULT_COLOR: cfg_q.default_color <= cfg_data;
				default: ;
			endcase
		end
	end

	tte_step #(
		.EscW   (EscW),
		.EscCap (ESCAPE_CAPACITY)
	) u_step (
		.ch             (char_s1),
		.cfg            (cfg_q),
		.cur            (cur_q),
		.esc            (esc_q),
		.esc_cnt        (esc_cnt_q),
		.esc_first      (esc_first_q),
		.esc_second     (esc_second_q),
		.nxt            (cur_nxt),
		.esc_nxt        (esc_nxt),
		.esc_cnt_nxt    (esc_cnt_nxt),
		.esc_first_nxt  (esc_first_nxt),
		.esc_second_nxt (esc_second_nxt),
		.cmds           (cmds),
		.n_cmds         (n_cmds)
	);

	assign adv = valid_s1 && (n_cmds == '0 || room);
	assign load = adv && n_cmds != '0;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cur_q <= '{col: 12'd0, row: 12'd0, fg: COL_WHITE};
			esc_q <= 1'b0;
			esc_cnt_q <= '0;
			esc_first_q <= '0;
			esc_second_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				cur_q <= cur_nxt;
				esc_q <= esc_nxt;
				esc_cnt_q <= esc_cnt_nxt;
				esc_first_q <= esc_first_nxt;
				esc_second_q <= esc_second_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
		end
	end

	tte_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.cmds      (cmds),
		.n_cmds    (n_cmds),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.head_last (last)
	);

	assign op = head.op;
	assign pos_x = head.x;
	assign pos_y = head.y;
	assign glyph_code = head.glyph;
	assign paint_color = head.color;

endmodule
`default_nettype wire
